// ----- hdl/es2cd_pkg.sv -----
// shared constants, types and tables for the seconds-to-civil-date converter
package es2cd_pkg;

  localparam int unsigned NUM_STAGES = 8;

  // seconds per day is 128 * 675
  localparam logic [9:0]  DAY_DIV_128    = 10'd675;
  localparam logic [25:0] DAY_RECIP      = 26'd50903317;
  localparam int unsigned DAY_SHIFT      = 35;

  localparam logic [16:0] WEEK_RECIP     = 17'd74899;
  localparam int unsigned WEEK_SHIFT     = 19;
  localparam logic [15:0] FIRST_WEEKDAY  = 16'd6;

  // one day in 1460 (four years) is a leap day, one in 36524 is taken back
  localparam logic [13:0] QUAD_RECIP     = 14'd11492;
  localparam int unsigned QUAD_SHIFT     = 22;
  localparam logic [15:0] CENTURY_DAYS   = 16'd36524;

  localparam logic [15:0] YEAR_RECIP     = 16'd45965;
  localparam int unsigned YEAR_SHIFT     = 24;
  localparam logic [15:0] DAYS_PER_YEAR  = 16'd365;

  localparam logic [12:0] HOUR_RECIP     = 13'd4661;
  localparam int unsigned HOUR_SHIFT     = 20;
  localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;

  localparam logic [10:0] MIN_RECIP      = 11'd1093;
  localparam int unsigned MIN_SHIFT      = 14;
  localparam logic [11:0] SECS_PER_MIN   = 12'd60;

  // days from jan 1 2000 to mar 1 2000
  localparam logic [15:0] MARCH_OFFSET   = 16'd60;
  localparam logic [5:0]  JAN_DAYS       = 6'd31;
  localparam logic [11:0] BASE_YEAR      = 12'd2000;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] vld;
  } flow_t;

  // first day of each month within a march-based year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/es2cd_flow.sv -----
// valid bits and stall chain for the converter pipeline
module es2cd_flow (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_ready,
  output es2cd_pkg::flow_t  ctl
);

  localparam int unsigned NS = es2cd_pkg::NUM_STAGES;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] en;

  // a stage moves when it is empty or its successor moves
  always_comb begin
    en[NS-1] = !vld_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.en  = en;
  assign ctl.vld = vld_r;

endmodule

// ----- hdl/epoch_seconds_to_civil_date.sv -----
// top level: seconds since 2000-01-01 to calendar date, weekday and time of day
// an accepted input beat passes through stages 0 to 7 of the constant-multiply pipeline
// throughput: one beat per cycle of the eight-stage pipeline unless the output stalls
// a stalled output holds full stages up to a gap; empty stages still fill behind it
// reset clears the stage valid bits only; data registers are not reset
module epoch_seconds_to_civil_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_seconds_since_epoch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_year,
  output logic [3:0]  out_month_number,
  output logic [4:0]  out_day_of_month,
  output logic [2:0]  out_weekday,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second_of_minute
);

  localparam int unsigned NS = es2cd_pkg::NUM_STAGES;

  es2cd_pkg::flow_t ctl;

  es2cd_flow u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  assign in_ready  = ctl.en[0];
  assign out_valid = ctl.vld[NS-1];

  // stage 0: day count by reciprocal multiply
  logic [31:0] s0_secs_r;
  logic [50:0] s0_pd_r;
  logic [50:0] s0_pd_nxt;

  assign s0_pd_nxt = {26'b0, in_seconds_since_epoch[31:7]} * {25'b0, es2cd_pkg::DAY_RECIP};

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s0_secs_r <= in_seconds_since_epoch;
      s0_pd_r   <= s0_pd_nxt;
    end
  end

  // stage 1: day products, weekday and leap-day estimates
  logic [15:0] s1_days;
  logic [25:0] s1_dm_nxt;
  logic [15:0] s1_wx_nxt;
  logic [32:0] s1_wp_nxt;
  logic [15:0] s1_mday_nxt;
  logic [27:0] s1_qp_nxt;
  logic [25:0] s1_dm_r;
  logic [15:0] s1_wx_r;
  logic [32:0] s1_wp_r;
  logic [15:0] s1_mday_r;
  logic [27:0] s1_qp_r;
  logic [16:0] s1_slo_r;
  logic        s1_lt60_r;
  logic [5:0]  s1_dlo_r;

  assign s1_days     = s0_pd_r[es2cd_pkg::DAY_SHIFT +: 16];
  assign s1_dm_nxt   = {10'b0, s1_days} * {16'b0, es2cd_pkg::DAY_DIV_128};
  assign s1_wx_nxt   = s1_days + es2cd_pkg::FIRST_WEEKDAY;
  assign s1_wp_nxt   = {17'b0, s1_wx_nxt} * {16'b0, es2cd_pkg::WEEK_RECIP};
  assign s1_mday_nxt = s1_days - es2cd_pkg::MARCH_OFFSET;
  assign s1_qp_nxt   = {14'b0, s1_mday_nxt[15:2]} * {14'b0, es2cd_pkg::QUAD_RECIP};

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      s1_dm_r   <= s1_dm_nxt;
      s1_wx_r   <= s1_wx_nxt;
      s1_wp_r   <= s1_wp_nxt;
      s1_mday_r <= s1_mday_nxt;
      s1_qp_r   <= s1_qp_nxt;
      s1_slo_r  <= s0_secs_r[16:0];
      s1_lt60_r <= s1_days < es2cd_pkg::MARCH_OFFSET;
      s1_dlo_r  <= s1_days[5:0];
    end
  end

  // stage 2: second of day, weekday, year numerator
  logic [13:0] s2_wq;
  logic [16:0] s2_wq7;
  logic [5:0]  s2_q1460;
  logic [16:0] s2_rem_nxt;
  logic [2:0]  s2_wd_nxt;
  logic [15:0] s2_n_nxt;
  logic [16:0] s2_rem_r;
  logic [2:0]  s2_wd_r;
  logic [15:0] s2_n_r;
  logic [15:0] s2_mday_r;
  logic        s2_lt60_r;
  logic [5:0]  s2_dlo_r;

  assign s2_wq      = s1_wp_r[es2cd_pkg::WEEK_SHIFT +: 14];
  assign s2_wq7     = {s2_wq, 3'b0} - {3'b0, s2_wq};
  assign s2_q1460   = s1_qp_r[es2cd_pkg::QUAD_SHIFT +: 6];
  assign s2_rem_nxt = s1_slo_r - {s1_dm_r[9:0], 7'b0};
  assign s2_wd_nxt  = s1_wx_r[2:0] - s2_wq7[2:0];
  assign s2_n_nxt   = s1_mday_r - {10'b0, s2_q1460}
                    + {15'b0, s1_mday_r >= es2cd_pkg::CENTURY_DAYS};

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      s2_rem_r  <= s2_rem_nxt;
      s2_wd_r   <= s2_wd_nxt;
      s2_n_r    <= s2_n_nxt;
      s2_mday_r <= s1_mday_r;
      s2_lt60_r <= s1_lt60_r;
      s2_dlo_r  <= s1_dlo_r;
    end
  end

  // stage 3: hour and year quotients
  logic [25:0] s3_hp_nxt;
  logic [31:0] s3_yp_nxt;
  logic [25:0] s3_hp_r;
  logic [31:0] s3_yp_r;
  logic [16:0] s3_rem_r;
  logic [2:0]  s3_wd_r;
  logic [15:0] s3_mday_r;
  logic        s3_lt60_r;
  logic [5:0]  s3_dlo_r;

  assign s3_hp_nxt = {13'b0, s2_rem_r[16:4]} * {13'b0, es2cd_pkg::HOUR_RECIP};
  assign s3_yp_nxt = {16'b0, s2_n_r} * {16'b0, es2cd_pkg::YEAR_RECIP};

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      s3_hp_r   <= s3_hp_nxt;
      s3_yp_r   <= s3_yp_nxt;
      s3_rem_r  <= s2_rem_r;
      s3_wd_r   <= s2_wd_r;
      s3_mday_r <= s2_mday_r;
      s3_lt60_r <= s2_lt60_r;
      s3_dlo_r  <= s2_dlo_r;
    end
  end

  // stage 4: pick quotients
  logic [4:0]  s4_hour_r;
  logic [7:0]  s4_yoe_r;
  logic [16:0] s4_rem_r;
  logic [2:0]  s4_wd_r;
  logic [15:0] s4_mday_r;
  logic        s4_lt60_r;
  logic [5:0]  s4_dlo_r;

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      s4_hour_r <= s3_hp_r[es2cd_pkg::HOUR_SHIFT +: 5];
      s4_yoe_r  <= s3_yp_r[es2cd_pkg::YEAR_SHIFT +: 8];
      s4_rem_r  <= s3_rem_r;
      s4_wd_r   <= s3_wd_r;
      s4_mday_r <= s3_mday_r;
      s4_lt60_r <= s3_lt60_r;
      s4_dlo_r  <= s3_dlo_r;
    end
  end

  // stage 5: second of hour, day of march-based year
  logic [16:0] s5_h3600;
  logic [16:0] s5_remh_full;
  logic [15:0] s5_ybase;
  logic [15:0] s5_doy_full;
  logic [11:0] s5_remh_r;
  logic [8:0]  s5_doy_r;
  logic [7:0]  s5_yoe_r;
  logic [4:0]  s5_hour_r;
  logic [2:0]  s5_wd_r;
  logic        s5_lt60_r;
  logic [5:0]  s5_dlo_r;

  assign s5_h3600     = {12'b0, s4_hour_r} * es2cd_pkg::SECS_PER_HOUR;
  assign s5_remh_full = s4_rem_r - s5_h3600;
  assign s5_ybase     = {8'b0, s4_yoe_r} * es2cd_pkg::DAYS_PER_YEAR
                      + {10'b0, s4_yoe_r[7:2]} - {15'b0, s4_yoe_r >= 8'd100};
  assign s5_doy_full  = s4_mday_r - s5_ybase;

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      s5_remh_r <= s5_remh_full[11:0];
      s5_doy_r  <= s5_doy_full[8:0];
      s5_yoe_r  <= s4_yoe_r;
      s5_hour_r <= s4_hour_r;
      s5_wd_r   <= s4_wd_r;
      s5_lt60_r <= s4_lt60_r;
      s5_dlo_r  <= s4_dlo_r;
    end
  end

  // stage 6: month search, minute quotient
  logic [3:0]  s6_mp_nxt;
  logic [20:0] s6_mnp_nxt;
  logic [3:0]  s6_mp_r;
  logic [20:0] s6_mnp_r;
  logic [11:0] s6_remh_r;
  logic [8:0]  s6_doy_r;
  logic [7:0]  s6_yoe_r;
  logic [4:0]  s6_hour_r;
  logic [2:0]  s6_wd_r;
  logic        s6_lt60_r;
  logic [5:0]  s6_dlo_r;

  always_comb begin
    s6_mp_nxt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      s6_mp_nxt = s6_mp_nxt + {3'b0, s5_doy_r >= es2cd_pkg::month_start(4'(k))};
    end
  end

  assign s6_mnp_nxt = {11'b0, s5_remh_r[11:2]} * {10'b0, es2cd_pkg::MIN_RECIP};

  always_ff @(posedge clk) begin
    if (ctl.en[6]) begin
      s6_mp_r   <= s6_mp_nxt;
      s6_mnp_r  <= s6_mnp_nxt;
      s6_remh_r <= s5_remh_r;
      s6_doy_r  <= s5_doy_r;
      s6_yoe_r  <= s5_yoe_r;
      s6_hour_r <= s5_hour_r;
      s6_wd_r   <= s5_wd_r;
      s6_lt60_r <= s5_lt60_r;
      s6_dlo_r  <= s5_dlo_r;
    end
  end

  // stage 7: output register
  logic [5:0]  s7_min;
  logic [11:0] s7_m60;
  logic [5:0]  s7_sec;
  logic [8:0]  s7_dom_full;
  logic        s7_jan_feb;
  logic [3:0]  s7_month;
  logic [11:0] s7_year;
  logic [4:0]  s7_dom;
  logic [11:0] s7_year_r;
  logic [3:0]  s7_month_r;
  logic [4:0]  s7_dom_r;
  logic [2:0]  s7_wd_r;
  logic [4:0]  s7_hour_r;
  logic [5:0]  s7_min_r;
  logic [5:0]  s7_sec_r;

  assign s7_min      = s6_mnp_r[es2cd_pkg::MIN_SHIFT +: 6];
  assign s7_m60      = {6'b0, s7_min} * es2cd_pkg::SECS_PER_MIN;
  assign s7_sec      = s6_remh_r[5:0] - s7_m60[5:0];
  assign s7_dom_full = s6_doy_r - es2cd_pkg::month_start(s6_mp_r) + 9'd1;
  assign s7_jan_feb  = s6_mp_r >= 4'd10;

  always_comb begin
    if (s6_lt60_r) begin
      s7_year = es2cd_pkg::BASE_YEAR;
      if (s6_dlo_r < es2cd_pkg::JAN_DAYS) begin
        s7_month = 4'd1;
        s7_dom   = s6_dlo_r[4:0] + 5'd1;
      end else begin
        s7_month = 4'd2;
        s7_dom   = 5'(s6_dlo_r - es2cd_pkg::JAN_DAYS + 6'd1);
      end
    end else begin
      s7_year  = es2cd_pkg::BASE_YEAR + {4'b0, s6_yoe_r} + {11'b0, s7_jan_feb};
      s7_month = s7_jan_feb ? s6_mp_r - 4'd9 : s6_mp_r + 4'd3;
      s7_dom   = s7_dom_full[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[7]) begin
      s7_year_r  <= s7_year;
      s7_month_r <= s7_month;
      s7_dom_r   <= s7_dom;
      s7_wd_r    <= s6_wd_r;
      s7_hour_r  <= s6_hour_r;
      s7_min_r   <= s7_min;
      s7_sec_r   <= s7_sec;
    end
  end

  assign out_year             = s7_year_r;
  assign out_month_number     = s7_month_r;
  assign out_day_of_month     = s7_dom_r;
  assign out_weekday          = s7_wd_r;
  assign out_hour             = s7_hour_r;
  assign out_minute           = s7_min_r;
  assign out_second_of_minute = s7_sec_r;

  // full pipeline with a stalled output must refuse new beats
  assert property (@(posedge clk) disable iff (!rst_n)
    (&ctl.vld && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline full and stalled");

  // an accepted beat lands in the first stage
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ctl.vld[0])
    else $error("accepted beat lost at pipeline entry");

  // result fields stay within calendar ranges
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_number >= 4'd1 && out_month_number <= 4'd12 &&
                   out_day_of_month != 5'd0 && out_weekday <= 3'd6 &&
                   out_hour <= 5'd23 && out_minute <= 6'd59 &&
                   out_second_of_minute <= 6'd59 && out_year >= 12'd2000))
    else $error("result field out of range");

  // reset empties the pipeline
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
